>>> hdl/rcarm_pkg.sv
// Shared types, constants and helper functions of the stick command receiver.
package rcarm_pkg;

  // Configuration port geometry.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Divider geometry of a scaling lane: a 25-bit dividend, a 9-bit divisor, a 16-bit quotient.
  localparam int unsigned QUOT_W            = 16;
  localparam int unsigned REM_W             = 9;
  localparam int unsigned PROD_W            = QUOT_W + REM_W;
  localparam int unsigned DIV_STEPS_DEFAULT = 4;

  // Packet and channel constants.
  localparam logic [23:0] HEADER_OK = 24'h3C4D24;  // '$','M','<' with byte 0 in the low bits
  localparam logic [10:0] CH_CENTER = 11'd1500;
  localparam logic [10:0] CH_MIN    = 11'd1000;
  localparam logic [10:0] CH_MAX    = 11'd2000;
  localparam logic [9:0]  CH_SPAN   = 10'd500;

  typedef enum logic [2:0] {
    REG_CODE_SET_CHANNELS = 3'd0,
    REG_CODE_ARM          = 3'd1,
    REG_CODE_DISARM       = 3'd2,
    REG_CODE_CALIBRATE    = 3'd3,
    REG_YAW_DEADBAND      = 3'd4,
    REG_TILT_DEADBAND     = 3'd5,
    REG_YAW_RATE_GAIN     = 3'd6,
    REG_TILT_ANGLE_GAIN   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ARM_DISARMED   = 2'd0,
    ARM_REQ_ARM    = 2'd1,
    ARM_REQ_DISARM = 2'd2,
    ARM_ARMED      = 2'd3
  } arm_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  code_set_channels;
    logic [7:0]  code_arm;
    logic [7:0]  code_disarm;
    logic [7:0]  code_calibrate;
    logic [8:0]  yaw_deadband;
    logic [8:0]  tilt_deadband;
    logic [15:0] yaw_rate_gain;
    logic [15:0] tilt_angle_gain;
  } cfg_t;

  // Sequencer commands to the scaling lanes.
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

  // Per-transaction fields that do not pass through a lane.
  typedef struct packed {
    logic [9:0] throttle_out;
    logic       armed;
    logic       disarm_pulse;
    logic       calibrate_pulse;
  } meta_t;

  function automatic logic [10:0] clamp_ch(input logic [15:0] v);
    logic [10:0] r;
    if (v < 16'(CH_MIN)) begin
      r = CH_MIN;
    end else if (v > 16'(CH_MAX)) begin
      r = CH_MAX;
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/rcarm_ifs.sv
// Valid/ready channel interfaces for the command items and the result items.
interface rcarm_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] header_bytes;
  logic [7:0]  command_byte;
  logic [15:0] throttle_raw;
  logic [15:0] yaw_raw;
  logic [15:0] pitch_raw;
  logic [15:0] roll_raw;
  logic        imu_ok;
  logic        battery_alarm;
  logic        landing_mode;

  modport source (
    output valid, operation, header_bytes, command_byte, throttle_raw, yaw_raw,
           pitch_raw, roll_raw, imu_ok, battery_alarm, landing_mode,
    input  ready
  );
  modport sink (
    input  valid, operation, header_bytes, command_byte, throttle_raw, yaw_raw,
           pitch_raw, roll_raw, imu_ok, battery_alarm, landing_mode,
    output ready
  );
endinterface

interface rcarm_result_if;
  logic               valid;
  logic               ready;
  logic [9:0]         throttle_out;
  logic signed [16:0] yaw_out;
  logic signed [16:0] pitch_out;
  logic signed [16:0] roll_out;
  logic               armed;
  logic               disarm_pulse;
  logic               calibrate_pulse;

  modport source (
    output valid, throttle_out, yaw_out, pitch_out, roll_out, armed, disarm_pulse,
           calibrate_pulse,
    input  ready
  );
  modport sink (
    input  valid, throttle_out, yaw_out, pitch_out, roll_out, armed, disarm_pulse,
           calibrate_pulse,
    output ready
  );
endinterface

>>> hdl/rcarm_cfg.sv
// APB-style configuration register file.
module rcarm_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcarm_pkg::ADDR_W-1:0] paddr,
  input  logic [rcarm_pkg::DATA_W-1:0] pwdata,
  output logic [rcarm_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output rcarm_pkg::cfg_t              cfg
);

  rcarm_pkg::reg_idx_t idx;

  assign idx    = rcarm_pkg::reg_idx_t'(paddr[rcarm_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_set_channels <= 8'd200;
      cfg.code_arm          <= 8'd201;
      cfg.code_disarm       <= 8'd202;
      cfg.code_calibrate    <= 8'd205;
      cfg.yaw_deadband      <= 9'd50;
      cfg.tilt_deadband     <= 9'd50;
      cfg.yaw_rate_gain     <= 16'd25600;
      cfg.tilt_angle_gain   <= 16'd7680;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        rcarm_pkg::REG_CODE_SET_CHANNELS: cfg.code_set_channels <= pwdata[7:0];
        rcarm_pkg::REG_CODE_ARM:          cfg.code_arm          <= pwdata[7:0];
        rcarm_pkg::REG_CODE_DISARM:       cfg.code_disarm       <= pwdata[7:0];
        rcarm_pkg::REG_CODE_CALIBRATE:    cfg.code_calibrate    <= pwdata[7:0];
        rcarm_pkg::REG_YAW_DEADBAND:      cfg.yaw_deadband      <= pwdata[8:0];
        rcarm_pkg::REG_TILT_DEADBAND:     cfg.tilt_deadband     <= pwdata[8:0];
        rcarm_pkg::REG_YAW_RATE_GAIN:     cfg.yaw_rate_gain     <= pwdata[15:0];
        rcarm_pkg::REG_TILT_ANGLE_GAIN:   cfg.tilt_angle_gain   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rcarm_pkg::REG_CODE_SET_CHANNELS: prdata = 32'(cfg.code_set_channels);
      rcarm_pkg::REG_CODE_ARM:          prdata = 32'(cfg.code_arm);
      rcarm_pkg::REG_CODE_DISARM:       prdata = 32'(cfg.code_disarm);
      rcarm_pkg::REG_CODE_CALIBRATE:    prdata = 32'(cfg.code_calibrate);
      rcarm_pkg::REG_YAW_DEADBAND:      prdata = 32'(cfg.yaw_deadband);
      rcarm_pkg::REG_TILT_DEADBAND:     prdata = 32'(cfg.tilt_deadband);
      rcarm_pkg::REG_YAW_RATE_GAIN:     prdata = 32'(cfg.yaw_rate_gain);
      rcarm_pkg::REG_TILT_ANGLE_GAIN:   prdata = 32'(cfg.tilt_angle_gain);
      default:                          prdata = '0;
    endcase
  end

endmodule

>>> hdl/rcarm_lane.sv
// One stick axis lane: clamp, deadband removal, gain multiply and iterative divide.
module rcarm_lane #(
  parameter int unsigned DIV_STEPS = rcarm_pkg::DIV_STEPS_DEFAULT
) (
  input  logic                 clk,
  input  rcarm_pkg::lane_ctl_t ctl,
  input  logic [15:0]          channel,
  input  logic [8:0]           deadband,
  input  logic [15:0]          gain,
  output logic signed [16:0]   value
);

  localparam int unsigned QW = rcarm_pkg::QUOT_W;
  localparam int unsigned RW = rcarm_pkg::REM_W;
  localparam int unsigned PW = rcarm_pkg::PROD_W;

  logic [10:0]   clamped;
  logic          neg;
  logic [RW-1:0] mag;
  logic          zero;
  logic [RW-1:0] diff;
  logic [PW-1:0] prod;
  logic [RW-1:0] divisor_init;

  // Divider state: remainder, and the dividend bits being replaced by quotient bits.
  logic [RW-1:0] rem;
  logic [QW-1:0] dq;
  logic [RW-1:0] divisor;
  logic          neg_r;
  logic          zero_r;
  logic [RW-1:0] rem_next;
  logic [QW-1:0] dq_next;
  logic [QW:0]   q_ext;

  always_comb begin
    clamped = rcarm_pkg::clamp_ch(channel);
    neg     = clamped < rcarm_pkg::CH_CENTER;
    mag     = neg ? RW'(rcarm_pkg::CH_CENTER - clamped) : RW'(clamped - rcarm_pkg::CH_CENTER);
    zero    = ({1'b0, deadband} >= rcarm_pkg::CH_SPAN) || (mag <= deadband);
    diff    = zero ? '0 : mag - deadband;
    prod    = PW'(diff) * PW'(gain);
    divisor_init = zero ? RW'(1) : RW'(rcarm_pkg::CH_SPAN - {1'b0, deadband});
  end

  // Restoring division, DIV_STEPS quotient bits per cycle. The quotient never
  // exceeds the gain, so the upper product bits already sit below the divisor.
  always_comb begin
    logic [RW:0] trial;
    logic        ge;
    rem_next = rem;
    dq_next  = dq;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial    = {rem_next, dq_next[QW-1]};
      ge       = trial >= {1'b0, divisor};
      rem_next = ge ? RW'(trial - {1'b0, divisor}) : trial[RW-1:0];
      dq_next  = {dq_next[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem     <= prod[PW-1:QW];
      dq      <= prod[QW-1:0];
      divisor <= divisor_init;
      neg_r   <= neg;
      zero_r  <= zero;
    end else if (ctl.step) begin
      rem <= rem_next;
      dq  <= dq_next;
    end
  end

  assign q_ext = {1'b0, dq};
  assign value = zero_r ? '0 : (neg_r ? $signed(17'(-q_ext)) : $signed(q_ext));

endmodule

>>> hdl/rcarm_merge.sv
// Merging stage: gathers lane results and side fields into the output register.
module rcarm_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  rcarm_pkg::meta_t      meta,
  input  logic signed [16:0]    yaw,
  input  logic signed [16:0]    pitch,
  input  logic signed [16:0]    roll,
  output logic                  free,
  rcarm_result_if.source        result
);

  logic valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.throttle_out    <= meta.throttle_out;
      result.yaw_out         <= yaw;
      result.pitch_out       <= pitch;
      result.roll_out        <= roll;
      result.armed           <= meta.armed;
      result.disarm_pulse    <= meta.disarm_pulse;
      result.calibrate_pulse <= meta.calibrate_pulse;
    end
  end

  assign result.valid = valid;
  assign free         = !valid || result.ready;

endmodule

>>> hdl/rc_command_receiver_arming_top.sv
// Top level of the stick command receiver with arming logic.
// Usage: command items arrive on the item channel (valid/ready); each one is
// either a received packet or a periodic process tick. Every accepted
// transaction yields exactly one transaction on the result channel. The
// packet's state effect (stick channels, arm request, calibration pulse) and
// the tick's effect (landing override, clamp write-back, arm resolution) are
// applied at the edge that accepts the item.
// Three scaling lanes (yaw, pitch, roll) then run in parallel; each does a
// restoring divide by (500 - deadband) with DIV_STEPS quotient bits a cycle,
// and the merging stage loads the output register.
// A new item is not taken while the lanes are dividing; the next item is
// taken in the same cycle as the result is loaded into the output register.
// A result waiting in the output register does not block a new item; only
// when the lanes finish while the old result is still untaken does the block
// hold its result and keep item.ready low until the receiver takes the old one.
// Reset (rst, synchronous) restores register defaults, all channels to 1500
// and the arm state to disarmed, and empties the output register.
// Configuration is an APB-style port, one register per 32-bit word.
module rc_command_receiver_arming_top #(
  parameter int unsigned DIV_STEPS = rcarm_pkg::DIV_STEPS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  rcarm_item_if.sink                   item,
  rcarm_result_if.source               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcarm_pkg::ADDR_W-1:0] paddr,
  input  logic [rcarm_pkg::DATA_W-1:0] pwdata,
  output logic [rcarm_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned DIV_CYCLES = rcarm_pkg::QUOT_W / DIV_STEPS;
  localparam int unsigned CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  rcarm_pkg::cfg_t cfg;

  rcarm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Architectural state: throttle, yaw, pitch, roll and the arm state.
  logic [15:0]           channels      [4];
  logic [15:0]           channels_next [4];
  rcarm_pkg::arm_state_t arm_state;
  rcarm_pkg::arm_state_t arm_state_next;
  rcarm_pkg::meta_t      meta;
  rcarm_pkg::meta_t      meta_next;

  logic accept;
  assign accept = item.valid && item.ready;

  // State update of one transaction, as seen at the accepting edge.
  always_comb begin
    logic       header_ok;
    logic       cal;
    logic       dis;
    logic [7:0] cmd;
    header_ok      = item.header_bytes == rcarm_pkg::HEADER_OK;
    cmd            = item.command_byte;
    cal            = 1'b0;
    dis            = 1'b0;
    arm_state_next = arm_state;
    for (int i = 0; i < 4; i++) begin
      channels_next[i] = channels[i];
    end
    if (!item.operation) begin
      if (header_ok) begin
        // Equal codes resolve in the order set, arm, disarm, calibrate.
        priority if (cmd == cfg.code_set_channels) begin
          channels_next[0] = item.throttle_raw;
          channels_next[1] = item.yaw_raw;
          channels_next[2] = item.pitch_raw;
          channels_next[3] = item.roll_raw;
        end else if (cmd == cfg.code_arm) begin
          arm_state_next = rcarm_pkg::ARM_REQ_ARM;
        end else if (cmd == cfg.code_disarm) begin
          arm_state_next = rcarm_pkg::ARM_REQ_DISARM;
        end else if (cmd == cfg.code_calibrate) begin
          cal = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        channels_next[i] = item.landing_mode ? 16'(rcarm_pkg::CH_CENTER)
                                             : 16'(rcarm_pkg::clamp_ch(channels[i]));
      end
      unique case (arm_state)
        rcarm_pkg::ARM_REQ_ARM: begin
          arm_state_next = (item.imu_ok && !item.battery_alarm) ? rcarm_pkg::ARM_ARMED
                                                                : rcarm_pkg::ARM_DISARMED;
        end
        rcarm_pkg::ARM_REQ_DISARM: begin
          arm_state_next = rcarm_pkg::ARM_DISARMED;
          dis            = 1'b1;
        end
        default: ;
      endcase
    end
    meta_next.throttle_out    = 10'(rcarm_pkg::clamp_ch(channels_next[0]) - rcarm_pkg::CH_MIN);
    meta_next.armed           = arm_state_next == rcarm_pkg::ARM_ARMED;
    meta_next.disarm_pulse    = dis;
    meta_next.calibrate_pulse = cal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        channels[i] <= 16'(rcarm_pkg::CH_CENTER);
      end
      arm_state <= rcarm_pkg::ARM_DISARMED;
    end else if (accept) begin
      for (int i = 0; i < 4; i++) begin
        channels[i] <= channels_next[i];
      end
      arm_state <= arm_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta <= meta_next;
    end
  end

  // Sequencer: lanes load on acceptance, step through the divide, then the
  // merging stage takes their values.
  rcarm_pkg::seq_state_t seq_state;
  rcarm_pkg::seq_state_t seq_state_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  rcarm_pkg::lane_ctl_t  lane_ctl;
  logic                  out_free;
  logic                  merge_load;
  logic                  ready_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= rcarm_pkg::SEQ_IDLE;
      cnt       <= '0;
    end else begin
      seq_state <= seq_state_next;
      cnt       <= cnt_next;
    end
  end

  always_comb begin
    seq_state_next = seq_state;
    cnt_next       = cnt;
    merge_load     = 1'b0;
    ready_int      = 1'b0;
    unique case (seq_state)
      rcarm_pkg::SEQ_IDLE: begin
        ready_int = 1'b1;
      end
      rcarm_pkg::SEQ_DIV: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          cnt_next       = '0;
          seq_state_next = rcarm_pkg::SEQ_DONE;
        end
      end
      rcarm_pkg::SEQ_DONE: begin
        if (out_free) begin
          merge_load     = 1'b1;
          ready_int      = 1'b1;
          seq_state_next = rcarm_pkg::SEQ_IDLE;
        end
      end
      default: begin
        seq_state_next = rcarm_pkg::SEQ_IDLE;
      end
    endcase
    if (accept) begin
      seq_state_next = rcarm_pkg::SEQ_DIV;
      cnt_next       = '0;
    end
    lane_ctl.load = accept;
    lane_ctl.step = seq_state == rcarm_pkg::SEQ_DIV;
  end

  assign item.ready = ready_int;

  logic signed [16:0] yaw_val;
  logic signed [16:0] pitch_val;
  logic signed [16:0] roll_val;

  rcarm_lane #(.DIV_STEPS(DIV_STEPS)) u_lane_yaw (
    .clk      (clk),
    .ctl      (lane_ctl),
    .channel  (channels_next[1]),
    .deadband (cfg.yaw_deadband),
    .gain     (cfg.yaw_rate_gain),
    .value    (yaw_val)
  );

  rcarm_lane #(.DIV_STEPS(DIV_STEPS)) u_lane_pitch (
    .clk      (clk),
    .ctl      (lane_ctl),
    .channel  (channels_next[2]),
    .deadband (cfg.tilt_deadband),
    .gain     (cfg.tilt_angle_gain),
    .value    (pitch_val)
  );

  rcarm_lane #(.DIV_STEPS(DIV_STEPS)) u_lane_roll (
    .clk      (clk),
    .ctl      (lane_ctl),
    .channel  (channels_next[3]),
    .deadband (cfg.tilt_deadband),
    .gain     (cfg.tilt_angle_gain),
    .value    (roll_val)
  );

  rcarm_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .load   (merge_load),
    .meta   (meta),
    .yaw    (yaw_val),
    .pitch  (pitch_val),
    .roll   (roll_val),
    .free   (out_free),
    .result (result)
  );

  // A tick always resolves a pending request.
  a_tick_resolves: assert property (@(posedge clk) disable iff (rst)
    $past(accept && item.operation) |->
      (arm_state == rcarm_pkg::ARM_DISARMED || arm_state == rcarm_pkg::ARM_ARMED))
    else $error("arm request left pending after a tick");

  // The disarm pulse comes only with a disarmed state.
  a_disarm_not_armed: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.disarm_pulse && result.armed))
    else $error("disarm pulse reported while armed");

  // A result never carries both the disarm pulse and the calibrate pulse.
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.disarm_pulse && result.calibrate_pulse))
    else $error("disarm and calibrate pulses in one result");

  // No item enters while the lanes are still dividing.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (seq_state == rcarm_pkg::SEQ_DIV) |-> !item.ready)
    else $error("item accepted while lanes busy");

endmodule
